[hw/rtl/jsu_pkg.sv]
// Shared types and constants for the JSON string unescaper.
// Holds the item structs, the decode mode enum and the state and output
// burst records. Depends on nothing.
package jsu_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_status;
      logic        status;
      logic [31:0] decoded_length;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      MODE_TEXT    = 4'd0,
      MODE_ESC     = 4'd1,
      MODE_HEX_A   = 4'd2,
      MODE_NEED_BS = 4'd3,
      MODE_NEED_U  = 4'd4,
      MODE_HEX_B   = 4'd5,
      MODE_UTF8    = 4'd6
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [20:0] code_accum;
      logic [9:0]  high_half;
      logic [2:0]  hex_seen;
      logic [1:0]  cont_left;
      logic [1:0]  min_class;
      logic        error_seen;
      logic [31:0] byte_count;
   } dec_state_type;

   // Up to four result items; element 0 leaves first.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            is_status;
      logic            status;
      logic [31:0]     length;
   } burst_type;

   localparam logic [31:0] LEN_MAX        = 32'hFFFF_FFFF;
   localparam logic [7:0]  CTRL_LIMIT     = 8'h20;
   localparam logic [7:0]  CH_BACKSLASH   = 8'h5C;
   localparam logic [7:0]  CH_QUOTE       = 8'h22;
   localparam logic [7:0]  CH_SLASH       = 8'h2F;
   localparam logic [7:0]  CH_B           = 8'h62;
   localparam logic [7:0]  CH_F           = 8'h66;
   localparam logic [7:0]  CH_N           = 8'h6E;
   localparam logic [7:0]  CH_R           = 8'h72;
   localparam logic [7:0]  CH_T           = 8'h74;
   localparam logic [7:0]  CH_U           = 8'h75;
   localparam logic [7:0]  LEAD2_LO       = 8'hC2;
   localparam logic [7:0]  LEAD2_HI       = 8'hDF;
   localparam logic [7:0]  LEAD3_LO       = 8'hE0;
   localparam logic [7:0]  LEAD3_HI       = 8'hEF;
   localparam logic [7:0]  LEAD4_LO       = 8'hF0;
   localparam logic [7:0]  LEAD4_HI       = 8'hF4;
   localparam logic [15:0] HIGH_SURR_LO   = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI   = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO    = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI    = 16'hDFFF;
   localparam logic [20:0] CP_MAX         = 21'h10FFFF;
   localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
   localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;

endpackage

[hw/rtl/jsu_decode.sv]
// Decoder state register and combinational step logic for one input item.
// Produces the burst of result items that the item causes.
// Depends on jsu_pkg.
module jsu_decode
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output burst_type burst_in
);

   dec_state_type st_ff;
   dec_state_type st_in;

   logic [7:0]  c;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] acc16;
   logic [20:0] acc21;
   logic [2:0]  hex_next;
   logic [1:0]  cont_next;
   logic [20:0] minimum;
   logic        do_fail;
   logic        cp_go;
   logic [20:0] cp;
   logic [2:0]  n_bytes;
   logic [32:0] count_sum;

   assign c = req_data.in_byte;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         hex_val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         hex_val = 4'(c - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc16     = {st_ff.code_accum[11:0], hex_val};
   assign acc21     = {st_ff.code_accum[14:0], c[5:0]};
   assign hex_next  = st_ff.hex_seen + 3'd1;
   assign cont_next = (st_ff.cont_left != 2'd0) ? st_ff.cont_left - 2'd1 : 2'd0;

   always_comb begin
      unique case (st_ff.min_class)
         2'd1:    minimum = 21'h000080;
         2'd2:    minimum = 21'h000800;
         default: minimum = 21'h010000;
      endcase
   end

   always_comb begin
      st_in     = st_ff;
      burst_in  = '0;
      do_fail   = 1'b0;
      cp_go     = 1'b0;
      cp        = '0;
      n_bytes   = 3'd0;
      count_sum = '0;

      if (req_data.end_of_string) begin
         burst_in.count     = 3'd1;
         burst_in.is_status = 1'b1;
         burst_in.status    = st_ff.error_seen | (st_ff.mode != MODE_TEXT);
         burst_in.length    = st_ff.byte_count;
         st_in              = '0;
         st_in.mode         = MODE_TEXT;
      end else if (!st_ff.error_seen) begin
         unique case (st_ff.mode)
            MODE_TEXT: begin
               if (c < CTRL_LIMIT) begin
                  do_fail = 1'b1;
               end else if (c == CH_BACKSLASH) begin
                  st_in.mode = MODE_ESC;
               end else if (!c[7]) begin
                  cp_go = 1'b1;
                  cp    = 21'(c);
               end else if (c >= LEAD2_LO && c <= LEAD2_HI) begin
                  st_in.mode       = MODE_UTF8;
                  st_in.cont_left  = 2'd1;
                  st_in.min_class  = 2'd1;
                  st_in.code_accum = 21'(c[4:0]);
               end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
                  st_in.mode       = MODE_UTF8;
                  st_in.cont_left  = 2'd2;
                  st_in.min_class  = 2'd2;
                  st_in.code_accum = 21'(c[3:0]);
               end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
                  st_in.mode       = MODE_UTF8;
                  st_in.cont_left  = 2'd3;
                  st_in.min_class  = 2'd3;
                  st_in.code_accum = 21'(c[2:0]);
               end else begin
                  do_fail = 1'b1;
               end
            end
            MODE_ESC: begin
               cp_go = 1'b1;
               if (c == CH_QUOTE || c == CH_BACKSLASH || c == CH_SLASH) begin
                  cp = 21'(c);
               end else if (c == CH_B) begin
                  cp = 21'h08;
               end else if (c == CH_F) begin
                  cp = 21'h0C;
               end else if (c == CH_N) begin
                  cp = 21'h0A;
               end else if (c == CH_R) begin
                  cp = 21'h0D;
               end else if (c == CH_T) begin
                  cp = 21'h09;
               end else if (c == CH_U) begin
                  cp_go            = 1'b0;
                  st_in.mode       = MODE_HEX_A;
                  st_in.code_accum = '0;
                  st_in.hex_seen   = 3'd0;
               end else begin
                  cp_go   = 1'b0;
                  do_fail = 1'b1;
               end
            end
            MODE_HEX_A, MODE_HEX_B: begin
               if (!hex_ok) begin
                  do_fail = 1'b1;
               end else begin
                  st_in.code_accum = 21'(acc16);
                  st_in.hex_seen   = hex_next;
                  if (hex_next == 3'd4) begin
                     st_in.hex_seen = 3'd0;
                     if (st_ff.mode == MODE_HEX_A) begin
                        if (acc16 >= HIGH_SURR_LO && acc16 <= HIGH_SURR_HI) begin
                           st_in.high_half = acc16[9:0];
                           st_in.mode      = MODE_NEED_BS;
                        end else if (acc16 >= LOW_SURR_LO && acc16 <= LOW_SURR_HI) begin
                           do_fail = 1'b1;
                        end else begin
                           cp_go = 1'b1;
                           cp    = 21'(acc16);
                        end
                     end else if (acc16 < LOW_SURR_LO || acc16 > LOW_SURR_HI) begin
                        do_fail = 1'b1;
                     end else begin
                        cp_go = 1'b1;
                        cp    = CP_SUPP_BASE + 21'({st_ff.high_half, acc16[9:0]});
                     end
                  end
               end
            end
            MODE_NEED_BS: begin
               if (c != CH_BACKSLASH) begin
                  do_fail = 1'b1;
               end else begin
                  st_in.mode = MODE_NEED_U;
               end
            end
            MODE_NEED_U: begin
               if (c != CH_U) begin
                  do_fail = 1'b1;
               end else begin
                  st_in.mode       = MODE_HEX_B;
                  st_in.code_accum = '0;
                  st_in.hex_seen   = 3'd0;
               end
            end
            MODE_UTF8: begin
               if (c[7:6] != 2'b10) begin
                  do_fail = 1'b1;
               end else begin
                  st_in.code_accum = acc21;
                  st_in.cont_left  = cont_next;
                  if (cont_next == 2'd0) begin
                     if (acc21 < minimum || acc21 > CP_MAX ||
                         (acc21 >= CP_SURR_LO && acc21 <= CP_SURR_HI)) begin
                        do_fail = 1'b1;
                     end else begin
                        cp_go = 1'b1;
                        cp    = acc21;
                     end
                  end
               end
            end
            default: begin
               do_fail = 1'b1;
            end
         endcase

         if (cp_go && cp == 21'd0) begin
            do_fail = 1'b1;
         end

         if (do_fail) begin
            st_in.error_seen = 1'b1;
            st_in.mode       = MODE_TEXT;
         end else if (cp_go) begin
            st_in.mode = MODE_TEXT;
            if (cp < 21'h000080) begin
               n_bytes           = 3'd1;
               burst_in.bytes[0] = cp[7:0];
            end else if (cp < 21'h000800) begin
               n_bytes           = 3'd2;
               burst_in.bytes[0] = {3'b110, cp[10:6]};
               burst_in.bytes[1] = {2'b10, cp[5:0]};
            end else if (cp < 21'h010000) begin
               n_bytes           = 3'd3;
               burst_in.bytes[0] = {4'b1110, cp[15:12]};
               burst_in.bytes[1] = {2'b10, cp[11:6]};
               burst_in.bytes[2] = {2'b10, cp[5:0]};
            end else begin
               n_bytes           = 3'd4;
               burst_in.bytes[0] = {5'b11110, cp[20:18]};
               burst_in.bytes[1] = {2'b10, cp[17:12]};
               burst_in.bytes[2] = {2'b10, cp[11:6]};
               burst_in.bytes[3] = {2'b10, cp[5:0]};
            end
            burst_in.count  = n_bytes;
            burst_in.length = (st_ff.byte_count == LEN_MAX) ? LEN_MAX
                                                            : st_ff.byte_count + 32'd1;
            count_sum        = {1'b0, st_ff.byte_count} + 33'(n_bytes);
            st_in.byte_count = count_sum[32] ? LEN_MAX : count_sum[31:0];
         end
      end
   end

   // MODE_TEXT is the all-zero code, so clearing the record sets text mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

endmodule

[hw/rtl/jsu_out_buf.sv]
// Result register for the unescaper: holds a burst of up to four result
// items and hands them out one per handshake. Depends on jsu_pkg.
module jsu_out_buf
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst_in,
   output logic      can_load,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   burst_type burst_ff;
   logic [2:0] count_ff;
   logic       pop;

   assign rsp_valid = count_ff != 3'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign can_load  = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_ready);

   assign rsp_data.out_byte       = burst_ff.is_status ? 8'h00 : burst_ff.bytes[0];
   assign rsp_data.is_status      = burst_ff.is_status;
   assign rsp_data.status         = burst_ff.status;
   assign rsp_data.decoded_length = burst_ff.length;
   assign rsp_data.last           = count_ff == 3'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else if (load && burst_in.count != 3'd0) begin
         count_ff <= burst_in.count;
      end else if (pop) begin
         count_ff <= count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load && burst_in.count != 3'd0) begin
         burst_ff <= burst_in;
      end else if (pop) begin
         burst_ff.bytes  <= {8'h00, burst_ff.bytes[3:1]};
         burst_ff.length <= (burst_ff.length == LEN_MAX) ? LEN_MAX
                                                         : burst_ff.length + 32'd1;
      end
   end

endmodule

[hw/rtl/json_string_unescape_utf8_top.sv]
// Top level of the JSON string unescaper with UTF-8 validation.
// Depends on jsu_pkg, jsu_decode and jsu_out_buf.
//
// Each item is one raw byte of a JSON string body, or an end item that
// closes the string. An item is decoded in the cycle it is accepted and its
// results, zero to four, land in the result register. An item that causes no
// result does not load the result register; an item that completes a code
// point of N UTF-8 bytes holds it until all N bytes leave, one byte per rsp
// handshake, and the next item is taken in the cycle the last leaves. With rsp
// always ready the block therefore sustains one input item per cycle except
// while multi-byte code points drain. The end item yields one status item
// and returns the block to its reset state for the next string.
module json_string_unescape_utf8_top
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      accept;
   logic      can_load;
   burst_type burst_in;

   assign req_ready = can_load;
   assign accept    = req_valid && req_ready;

   jsu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .burst_in (burst_in)
   );

   jsu_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst_in  (burst_in),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/jsu_checker.sv]
// Port-level checker for the unescaper top level, bound to it below.
// Depends on jsu_pkg and json_string_unescape_utf8_top.
module jsu_checker
   import jsu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("A stalled result item changed or was dropped.");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_status |-> rsp_data.last && rsp_data.out_byte == 8'h00)
      else $error("A status item is not the last item or carries a byte.");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_status |-> rsp_data.out_byte != 8'h00 && !rsp_data.status)
      else $error("A data item carries a zero byte or a status flag.");

   a_burst_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid && !rsp_data.is_status &&
      (rsp_data.decoded_length == $past(rsp_data.decoded_length) + 32'd1 ||
       $past(rsp_data.decoded_length) == LEN_MAX))
      else $error("A burst of bytes broke off or its length did not advance.");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
